// ----- rtl/srt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

  localparam int BLOCK_BITS = 32;
  localparam int REQ_BITS = 3;
  localparam int STATUS_BITS = 2;

  typedef logic [REQ_BITS-1:0] req_t;
  typedef logic [STATUS_BITS-1:0] status_t;

  localparam req_t REQ_INSERT  = 3'd0;
  localparam req_t REQ_COVER   = 3'd1;
  localparam req_t REQ_LOWER   = 3'd2;
  localparam req_t REQ_UPPER   = 3'd3;
  localparam req_t REQ_NEAREST = 3'd4;

  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_NOTFOUND = 2'd1;
  localparam status_t STAT_FULL     = 2'd2;
  localparam status_t STAT_EMPTY    = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/sorted_run_range_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | beat ports                                          | handshake
// request  | in  | req_type query_key run_first_key run_last_key       | start & !busy
//          |     | run_block                                           |
// result   | out | status found_index found_first_key found_last_key   | done, one cycle
//          |     | found_block run_count level_low_key level_high_key  |
//
// Insert, full, empty and unused requests answer in the cycle after the beat.
// A search runs bisection steps, each a memory read then a compare, for at most
// clog2(DEPTH)+1 steps, then re-reads the answer entry when needed and gives the
// result beat. The single table read port and the key compares of each step set
// this pace. Reset clears the run count, sets the low level bound to all ones and
// the high one to zero; table entries are undefined until inserted. busy stays
// high until the result cycle; the receiver cannot stall.

module sorted_run_range_table #(
  parameter int DEPTH = 64,
  parameter int KEY_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [srt_pkg::REQ_BITS-1:0]       req_type,
  input  wire logic [KEY_BITS-1:0]                query_key,
  input  wire logic [KEY_BITS-1:0]                run_first_key,
  input  wire logic [KEY_BITS-1:0]                run_last_key,
  input  wire logic [srt_pkg::BLOCK_BITS-1:0]     run_block,
  output logic                                    done,
  output logic [srt_pkg::STATUS_BITS-1:0]         status,
  output logic [$clog2(DEPTH+1)-1:0]              found_index,
  output logic [KEY_BITS-1:0]                     found_first_key,
  output logic [KEY_BITS-1:0]                     found_last_key,
  output logic [srt_pkg::BLOCK_BITS-1:0]          found_block,
  output logic [$clog2(DEPTH+1)-1:0]              run_count,
  output logic [KEY_BITS-1:0]                     level_low_key,
  output logic [KEY_BITS-1:0]                     level_high_key
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW = 2 * KEY_BITS + srt_pkg::BLOCK_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_FOUT  = 3'd4;

  logic [2:0]          state;
  srt_pkg::req_t       req;
  logic [KEY_BITS-1:0] q;
  logic [CW-1:0]       s;
  logic [CW-1:0]       e_p1;
  logic [CW-1:0]       mid_r;
  logic [CW-1:0]       idx_r;
  logic [CW-1:0]       count;
  logic [KEY_BITS-1:0] low_bound;
  logic [KEY_BITS-1:0] high_bound;

  logic [MW-1:0]       mem [DEPTH];
  logic [MW-1:0]       rdata;
  logic [IW-1:0]       raddr;
  logic                we;

  logic [KEY_BITS-1:0]            rd_first;
  logic [KEY_BITS-1:0]            rd_last;
  logic [srt_pkg::BLOCK_BITS-1:0] rd_block;

  logic          c1_gt, c1_lt, c2_lt, cover_hit;
  logic [CW-1:0] mid_calc, s_next, e_p1_next, mid_exit, mid_inc;
  logic          loop_end;
  logic [KEY_BITS-1:0] low_next, high_next;

  // (s + e) / 2 truncated toward zero, with e carried as e + 1
  function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] sum;
    logic [CW:0] half;
    sum = {1'b0, a} + {1'b0, b};
    half = (sum == '0) ? '0 : ((sum - (CW+1)'(1)) >> 1);
    return half[CW-1:0];
  endfunction

  assign busy = (state != S_IDLE);
  assign run_count = count;
  assign level_low_key = low_bound;
  assign level_high_key = high_bound;

  assign rd_first = rdata[MW-1 -: KEY_BITS];
  assign rd_last  = rdata[srt_pkg::BLOCK_BITS +: KEY_BITS];
  assign rd_block = rdata[srt_pkg::BLOCK_BITS-1:0];

  always_comb begin
    mid_calc = mid_of(s, e_p1);
    c1_gt = (rd_first > q);
    c1_lt = (rd_first < q);
    c2_lt = (rd_last < q);
    cover_hit = !c1_gt && !c2_lt;
    if (c1_gt) begin
      s_next = s;
      e_p1_next = mid_r;
    end else begin
      s_next = mid_r + CW'(1);
      e_p1_next = e_p1;
    end
    loop_end = (s_next >= e_p1_next);
    mid_exit = mid_of(s_next, e_p1_next);
    mid_inc = mid_r + CW'(1);
    raddr = (state == S_FETCH) ? idx_r[IW-1:0] : mid_calc[IW-1:0];
    we = (state == S_IDLE) && start && (req_type == srt_pkg::REQ_INSERT)
         && (count != CW'(DEPTH));
    low_next = low_bound;
    high_next = high_bound;
    if (run_first_key < low_next) low_next = run_first_key;
    if (run_last_key < low_next) low_next = run_last_key;
    if (run_first_key > high_next) high_next = run_first_key;
    if (run_last_key > high_next) high_next = run_last_key;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[count[IW-1:0]] <= {run_first_key, run_last_key, run_block};
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      count <= '0;
      low_bound <= '1;
      high_bound <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req <= req_type;
            q <= query_key;
            s <= '0;
            e_p1 <= count;
            found_index <= '0;
            found_first_key <= '0;
            found_last_key <= '0;
            found_block <= '0;
            if (req_type == srt_pkg::REQ_INSERT) begin
              done <= 1'b1;
              if (count == CW'(DEPTH)) begin
                status <= srt_pkg::STAT_FULL;
              end else begin
                status <= srt_pkg::STAT_OK;
                found_index <= count;
                found_first_key <= run_first_key;
                found_last_key <= run_last_key;
                found_block <= run_block;
                count <= count + CW'(1);
                low_bound <= low_next;
                high_bound <= high_next;
              end
            end else if (req_type > srt_pkg::REQ_NEAREST) begin
              done <= 1'b1;
              status <= srt_pkg::STAT_NOTFOUND;
            end else if (count == '0) begin
              done <= 1'b1;
              status <= srt_pkg::STAT_EMPTY;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          mid_r <= mid_calc;
          state <= S_CMP;
        end
        S_CMP: begin
          s <= s_next;
          e_p1 <= e_p1_next;
          state <= S_RD;
          case (req)
            srt_pkg::REQ_COVER: begin
              if (cover_hit) begin
                state <= S_IDLE;
                done <= 1'b1;
                status <= srt_pkg::STAT_OK;
                found_index <= mid_r;
                found_first_key <= rd_first;
                found_last_key <= rd_last;
                found_block <= rd_block;
              end else if (loop_end) begin
                state <= S_IDLE;
                done <= 1'b1;
                status <= srt_pkg::STAT_NOTFOUND;
              end
            end
            srt_pkg::REQ_LOWER, srt_pkg::REQ_UPPER: begin
              if ((cover_hit && req == srt_pkg::REQ_LOWER)
                  || (!cover_hit && loop_end && c1_gt)) begin
                state <= S_IDLE;
                done <= 1'b1;
                status <= srt_pkg::STAT_OK;
                found_index <= mid_r;
                found_first_key <= rd_first;
                found_last_key <= rd_last;
                found_block <= rd_block;
              end else if (cover_hit || loop_end) begin
                if (mid_inc < count) begin
                  idx_r <= mid_inc;
                  state <= S_FETCH;
                end else begin
                  // upper bound past the last run answers index count, no fields; a miss there is not found
                  state <= S_IDLE;
                  done <= 1'b1;
                  status <= cover_hit ? srt_pkg::STAT_OK : srt_pkg::STAT_NOTFOUND;
                  found_index <= cover_hit ? mid_inc : '0;
                end
              end
            end
            default: begin
              if (!c1_gt && !c1_lt) begin
                state <= S_IDLE;
                done <= 1'b1;
                status <= srt_pkg::STAT_OK;
                found_index <= mid_r;
                found_first_key <= rd_first;
                found_last_key <= rd_last;
                found_block <= rd_block;
              end else if (loop_end) begin
                idx_r <= mid_exit;
                state <= S_FETCH;
              end
            end
          endcase
        end
        S_FETCH: begin
          state <= S_FOUT;
        end
        S_FOUT: begin
          state <= S_IDLE;
          done <= 1'b1;
          status <= srt_pkg::STAT_OK;
          found_index <= idx_r;
          found_first_key <= rd_first;
          found_last_key <= rd_last;
          found_block <= rd_block;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("run count above depth");

  a_search_keeps_count: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(count))
    else $error("run count changed during a search");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (done && status == srt_pkg::STAT_OK) |-> found_index <= run_count)
    else $error("answered index beyond run count");

  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> low_bound <= high_bound)
    else $error("level bounds inverted");

endmodule

`default_nettype wire
